/* hw/rtl/csc_pkg.sv */
// Shared types, constants and width helpers for the chromaticity core.
// Used by every module of the block; depends on nothing else.

package csc_pkg;

    // Defaults for the top-level parameters
    localparam int COUNT_BITS_DEF     = 16;
    localparam int COEF_FRAC_BITS_DEF = 14;
    localparam int QUEUE_DEPTH_DEF    = 4;

    // Field widths of the stream items
    localparam int CTRL_W      = 8;
    localparam int CNT_FIELD_W = 16;
    localparam int CHROMA_W    = 16;
    localparam int STATUS_W    = 2;
    localparam int IN_DATA_W   = 56;
    localparam int OUT_DATA_W  = 48;

    // Bit positions of the input fields inside s_tdata
    localparam int CTRL_LSB  = 0;
    localparam int RED_LSB   = 8;
    localparam int GREEN_LSB = 24;
    localparam int BLUE_LSB  = 40;

    // Configuration port
    localparam int LIMIT_W     = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_REJECT_LIMIT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_READY_CODE   = 1'b1;

    localparam logic [LIMIT_W-1:0] REJECT_LIMIT_RST = 16'd200;
    localparam logic [CTRL_W-1:0]  READY_CODE_RST   = 8'h13;

    // Fractional bits of the chromaticity outputs (Q4.12)
    localparam int OUT_FRAC_BITS = 12;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_NOT_READY  = 2'd1,
        ST_OVER_LIMIT = 2'd2,
        ST_ZERO_SUM   = 2'd3
    } status_t;

    // RGB to XYZ matrix in units of 1e-5; rows X, Y, Z, columns R, G, B
    localparam longint DEC_SCALE = 100000;
    localparam int MAT_DEC [0:8] = '{
        -14282, 154924, -95641,
        -32466, 157837, -73191,
        -68202,  77073,  56332
    };

    // Coefficient in fixed point, rounded to nearest, ties away from zero
    function automatic longint coef_fixed(input int dec, input int frac);
        longint mag;
        longint num;
        longint q;
        mag = (dec < 0) ? -longint'(dec) : longint'(dec);
        num = (mag <<< frac) * 2 + DEC_SCALE;
        q   = num / (2 * DEC_SCALE);
        return (dec < 0) ? -q : q;
    endfunction

    // Count bits actually used from each 16-bit field
    function automatic int count_w(input int cb);
        return (cb < CNT_FIELD_W) ? cb : CNT_FIELD_W;
    endfunction

    // Signed width of one coefficient times count product
    function automatic int prod_w(input int cb, input int fb);
        return fb + count_w(cb) + 3;
    endfunction

    // Signed width of X, Y or Z
    function automatic int v_w(input int cb, input int fb);
        return prod_w(cb, fb) + 2;
    endfunction

    // Signed width of the sum X+Y+Z
    function automatic int s_w(input int cb, input int fb);
        return v_w(cb, fb) + 2;
    endfunction

    // Width of the divider remainder path
    function automatic int div_w(input int cb, input int fb);
        return s_w(cb, fb) + CHROMA_W + 1;
    endfunction

    // Width of one queue entry: status, X, Y, Z, sum
    function automatic int entry_w(input int cb, input int fb);
        return STATUS_W + 3 * v_w(cb, fb) + s_w(cb, fb);
    endfunction

endpackage

/* hw/rtl/csc_front.sv */
// Front end of the chromaticity core: configuration registers, sample
// classification and the RGB to XYZ matrix pipeline. Depends on csc_pkg.

module csc_front import csc_pkg::*; #(
    parameter int COUNT_BITS     = COUNT_BITS_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         cfg_we,
    input  logic [CFG_INDEX_W-1:0]                       cfg_index,
    input  logic [CFG_DATA_W-1:0]                        cfg_wdata,
    input  logic                                         s_tvalid,
    output logic                                         s_tready,
    // control_byte, red_count, green_count, blue_count
    input  logic [IN_DATA_W-1:0]                         s_tdata,
    input  logic                                         q_full,
    output logic                                         q_push,
    // status, X, Y, Z, sum
    output logic [entry_w(COUNT_BITS, COEF_FRAC_BITS)-1:0] q_wdata
);

    localparam int CW  = count_w(COUNT_BITS);
    localparam int CFW = COEF_FRAC_BITS + 2;
    localparam int PW  = prod_w(COUNT_BITS, COEF_FRAC_BITS);
    localparam int VW  = v_w(COUNT_BITS, COEF_FRAC_BITS);
    localparam int SW  = s_w(COUNT_BITS, COEF_FRAC_BITS);

    logic [LIMIT_W-1:0] reject_limit_reg;
    logic [CTRL_W-1:0]  ready_code_reg;

    logic [CTRL_W-1:0]    ctrl;
    logic [CW-1:0]        cnt [0:2];
    logic                 over;
    status_t              s1_st_next;
    logic signed [PW-1:0] prod [0:8];

    logic                 en;
    logic                 s1_vld_reg;
    status_t              s1_st_reg;
    logic signed [PW-1:0] s1_prod_reg [0:8];
    logic                 s2_vld_reg;
    status_t              s2_st_reg;
    logic signed [VW-1:0] s2_v_reg [0:2];
    logic signed [SW-1:0] s3_s_next;
    logic                 s3_vld_reg;
    status_t              s3_st_reg;
    logic signed [VW-1:0] s3_v_reg [0:2];
    logic signed [SW-1:0] s3_s_reg;

    // Hold the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reject_limit_reg <= REJECT_LIMIT_RST;
            ready_code_reg   <= READY_CODE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_REJECT_LIMIT: reject_limit_reg <= cfg_wdata[LIMIT_W-1:0];
                REG_READY_CODE:   ready_code_reg   <= cfg_wdata[CTRL_W-1:0];
                default:          ;
            endcase
        end
    end

    // Unpack the item; only the low count bits take part
    assign ctrl   = s_tdata[CTRL_LSB +: CTRL_W];
    assign cnt[0] = s_tdata[RED_LSB +: CW];
    assign cnt[1] = s_tdata[GREEN_LSB +: CW];
    assign cnt[2] = s_tdata[BLUE_LSB +: CW];

    // Classify: not ready first, then over limit
    assign over = (LIMIT_W'(cnt[0]) > reject_limit_reg) ||
                  (LIMIT_W'(cnt[1]) > reject_limit_reg) ||
                  (LIMIT_W'(cnt[2]) > reject_limit_reg);

    always_comb
    begin
        if (ctrl != ready_code_reg)
            s1_st_next = ST_NOT_READY;
        else if (over)
            s1_st_next = ST_OVER_LIMIT;
        else
            s1_st_next = ST_OK;
    end

    // One multiplier per matrix coefficient
    for (genvar r = 0; r < 3; r++)
    begin : g_row
        for (genvar c = 0; c < 3; c++)
        begin : g_col
            localparam logic signed [CFW-1:0] COEF =
                CFW'(coef_fixed(MAT_DEC[r*3+c], COEF_FRAC_BITS));
            assign prod[r*3+c] = PW'(COEF) * PW'($signed({1'b0, cnt[c]}));
        end
    end

    // Advance the whole front while the last stage can leave
    assign en       = !s3_vld_reg || !q_full;
    assign s_tready = en;
    assign q_push   = s3_vld_reg && !q_full;

    assign s3_s_next = SW'(s2_v_reg[0]) + SW'(s2_v_reg[1]) + SW'(s2_v_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= s_tvalid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    // Products, then X/Y/Z, then the sum with the zero check
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_st_reg   <= s1_st_next;
            s1_prod_reg <= prod;
            s2_st_reg   <= s1_st_reg;
            for (int k = 0; k < 3; k++)
            begin
                s2_v_reg[k] <= VW'(s1_prod_reg[k*3])   + VW'(s1_prod_reg[k*3+1]) +
                               VW'(s1_prod_reg[k*3+2]);
            end
            s3_v_reg <= s2_v_reg;
            s3_s_reg <= s3_s_next;
            if (s2_st_reg == ST_OK && s3_s_next == '0)
                s3_st_reg <= ST_ZERO_SUM;
            else
                s3_st_reg <= s2_st_reg;
        end
    end

    assign q_wdata = {s3_s_reg, s3_v_reg[2], s3_v_reg[1], s3_v_reg[0], s3_st_reg};

endmodule

/* hw/rtl/csc_queue.sv */
// Short register queue between the front and back of the chromaticity core.
// Depends on csc_pkg for its default depth.

module csc_queue import csc_pkg::*; #(
    parameter int WIDTH = 1,
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CNTW-1:0]  count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNTW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // Store the entry at the write pointer
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    // Advance pointers and track the fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

/* hw/rtl/csc_back.sv */
// Back end of the chromaticity core: pipelined restoring divider giving
// X/S, Y/S and Z/S, rounding, saturation and the output register.
// Depends on csc_pkg.

module csc_back import csc_pkg::*; #(
    parameter int COUNT_BITS     = COUNT_BITS_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         q_empty,
    // status, X, Y, Z, sum
    input  logic [entry_w(COUNT_BITS, COEF_FRAC_BITS)-1:0] q_rdata,
    output logic                                         q_pop,
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    // chroma_x, chroma_y, chroma_z
    output logic [OUT_DATA_W-1:0]                        m_tdata,
    // status
    output logic [STATUS_W-1:0]                          m_tuser
);

    localparam int VW = v_w(COUNT_BITS, COEF_FRAC_BITS);
    localparam int SW = s_w(COUNT_BITS, COEF_FRAC_BITS);
    localparam int UW = div_w(COUNT_BITS, COEF_FRAC_BITS);
    localparam int QB = CHROMA_W;

    localparam logic [QB-1:0] SAT_POS = {1'b0, {(QB-1){1'b1}}};
    localparam logic [QB-1:0] SAT_NEG = {1'b1, {(QB-1){1'b0}}};

    logic                 en;
    status_t              in_st;
    logic signed [VW-1:0] in_v [0:2];
    logic signed [SW-1:0] in_s;
    logic                 s_neg;
    logic [SW-1:0]        ms;
    logic [VW-1:0]        mv [0:2];
    logic [UW-1:0]        num [0:2];
    logic [UW-1:0]        den;
    logic [2:0]           ovf;
    logic [2:0]           neg;

    logic                 vld_reg  [0:QB];
    status_t              st_reg   [0:QB];
    logic [2:0]           neg_reg  [0:QB];
    logic [2:0]           ovf_reg  [0:QB];
    logic [UW-1:0]        d_reg    [0:QB-1];
    logic [UW-1:0]        rem_reg  [0:QB-1][0:2];
    logic [QB-1:0]        q_reg    [1:QB][0:2];

    logic [QB-1:0]        res [0:2];
    logic                 out_vld_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    status_t              out_st_reg;

    // Advance the whole back end while the output register can take an item
    assign en    = !out_vld_reg || m_tready;
    assign q_pop = en && !q_empty;

    // Unpack the queue entry
    assign in_st = status_t'(q_rdata[STATUS_W-1:0]);
    assign in_s  = $signed(q_rdata[STATUS_W + 3*VW +: SW]);
    for (genvar k = 0; k < 3; k++)
    begin : g_unpack
        assign in_v[k] = $signed(q_rdata[STATUS_W + k*VW +: VW]);
    end

    // Set up magnitudes: quotient = (|V|*2^13 + |S|) / (2|S|)
    assign s_neg = in_s[SW-1];
    assign ms    = s_neg ? SW'(-in_s) : SW'(in_s);
    assign den   = UW'(ms) << 1;

    for (genvar k = 0; k < 3; k++)
    begin : g_prep
        assign mv[k]  = in_v[k][VW-1] ? VW'(-in_v[k]) : VW'(in_v[k]);
        assign num[k] = (UW'(mv[k]) << (OUT_FRAC_BITS + 1)) + UW'(ms);
        assign neg[k] = in_v[k][VW-1] ^ s_neg;
        assign ovf[k] = num[k] >= (den << QB);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= !q_empty;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0]  <= in_st;
            neg_reg[0] <= neg;
            ovf_reg[0] <= ovf;
            d_reg[0]   <= den;
            for (int k = 0; k < 3; k++)
                rem_reg[0][k] <= num[k];
        end
    end

    // One quotient bit per stage, most significant first
    for (genvar j = 0; j < QB; j++)
    begin : g_step
        localparam int SH = QB - 1 - j;

        logic [QB-1:0] q_in [0:2];
        logic [UW-1:0] dsh;
        logic [2:0]    take;

        assign dsh = d_reg[j] << SH;

        for (genvar k = 0; k < 3; k++)
        begin : g_lane
            assign take[k] = rem_reg[j][k] >= dsh;
            if (j == 0)
            begin : g_first
                assign q_in[k] = '0;
            end
            else
            begin : g_next
                assign q_in[k] = q_reg[j][k];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[j+1] <= 1'b0;
            else if (en)
                vld_reg[j+1] <= vld_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[j+1]  <= st_reg[j];
                neg_reg[j+1] <= neg_reg[j];
                ovf_reg[j+1] <= ovf_reg[j];
                for (int k = 0; k < 3; k++)
                    q_reg[j+1][k] <= q_in[k] | (QB'(take[k]) << SH);
            end
        end

        // Carry the partial remainder to the next stage
        if (j < QB - 1)
        begin : g_carry
            logic [UW-1:0] rem_sub [0:2];

            for (genvar k = 0; k < 3; k++)
            begin : g_sub
                assign rem_sub[k] = rem_reg[j][k] - dsh;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    d_reg[j+1] <= d_reg[j];
                    for (int k = 0; k < 3; k++)
                        rem_reg[j+1][k] <= take[k] ? rem_sub[k] : rem_reg[j][k];
                end
            end
        end
    end

    // Apply the sign, saturate, and drop the result unless status is ok
    for (genvar k = 0; k < 3; k++)
    begin : g_final
        always_comb
        begin
            if (st_reg[QB] != ST_OK)
                res[k] = '0;
            else if (neg_reg[QB][k])
                res[k] = (ovf_reg[QB][k] || q_reg[QB][k] > SAT_NEG) ? SAT_NEG
                                                                    : -q_reg[QB][k];
            else
                res[k] = (ovf_reg[QB][k] || q_reg[QB][k][QB-1]) ? SAT_POS : q_reg[QB][k];
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= vld_reg[QB];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= {res[2], res[1], res[0]};
            out_st_reg   <= st_reg[QB];
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_st_reg;

endmodule

/* hw/rtl/color_sensor_chromaticity_core.sv */
// Top level of the colour sensor chromaticity core: front end, queue and
// divider back end. Depends on csc_pkg, csc_front, csc_queue and csc_back.
//
// Usage:
//   s_* carries one sensor sample per item (control byte and RGB counts).
//   m_* returns one result per sample: status in m_tuser, chromaticity
//   x, y, z in signed Q4.12 in m_tdata; all three are zero unless status is ok.
//   cfg_we/cfg_index/cfg_wdata write the reject limit (index 0) and the ready
//   code (index 1); write them only while no item is in flight.
// Timing:
//   From input to output an item passes through three matrix stages, the
//   queue, a set-up stage, sixteen divider stages (one quotient bit each)
//   and the output register.
//   Throughput is one item per cycle while the receiver does not stall;
//   every stage of the divider pipeline holds its own item.
// Reset:
//   rst_n clears all valid flags and the queue and loads the reset values of
//   both configuration registers (reject limit 200, ready code 0x13).
// Stalls:
//   A stalled receiver freezes the back end; the front keeps accepting until
//   the queue fills, then s_tready drops.

module color_sensor_chromaticity_core import csc_pkg::*; #(
    parameter int COUNT_BITS     = COUNT_BITS_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // control_byte, red_count, green_count, blue_count
    input  logic [IN_DATA_W-1:0]   s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // chroma_x, chroma_y, chroma_z
    output logic [OUT_DATA_W-1:0]  m_tdata,
    // status
    output logic [STATUS_W-1:0]    m_tuser
);

    localparam int EW = entry_w(COUNT_BITS, COEF_FRAC_BITS);

    logic          q_push;
    logic          q_full;
    logic [EW-1:0] q_wdata;
    logic          q_pop;
    logic          q_empty;
    logic [EW-1:0] q_rdata;

    csc_front #(
        .COUNT_BITS     (COUNT_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_wdata   (q_wdata)
    );

    csc_queue #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    csc_back #(
        .COUNT_BITS     (COUNT_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_rdata  (q_rdata),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
